@@ rtl/core/button_debounce_with_activity_core_defines.svh @@
// Assertion macros shared by the checker of the button debounce core.
// Depends on a clock and a reset signal being visible at the point of use.
`ifndef BUTTON_DEBOUNCE_WITH_ACTIVITY_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_WITH_ACTIVITY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BDWA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDWA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/bdwa_pkg.sv @@
// Package of the button debounce core: sizes, register indexes, lane structs
// and the history bit counter. No dependencies.
package bdwa_pkg;

   localparam int BUTTONS      = 3;
   localparam int HISTORY_BITS = 8;
   localparam int TIME_W       = 32;
   localparam int THR_W        = 4;
   localparam int TIMEOUT_W    = 8;
   localparam int CNT_W        = $clog2(HISTORY_BITS + 1);
   localparam int CMP_W        = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int UNIT_MS      = 5 * 1000;
   localparam int LIMIT_W      = TIMEOUT_W + $clog2(UNIT_MS);

   localparam logic [LIMIT_W-1:0]      TIMEOUT_UNIT_MS = LIMIT_W'(UNIT_MS);
   localparam logic [HISTORY_BITS-1:0] WAKE_HISTORY    = HISTORY_BITS'(4);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = (BUTTONS > TIMEOUT_W) ? BUTTONS : TIMEOUT_W;

   localparam logic [CSR_ADDR_W-1:0] REG_SLEEP_TIMEOUT     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_HANDLER_ENABLE    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_PRESS_THRESHOLD   = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] REG_RELEASE_THRESHOLD = CSR_ADDR_W'(3);

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);

   typedef struct packed {
      logic action;
      logic pressed;
      logic accept;
      logic enable;
      logic sleeping;
   } lane_in_type;

   typedef struct packed {
      logic [THR_W-1:0]   press_thr;
      logic [THR_W-1:0]   release_thr;
      logic [LIMIT_W-1:0] limit;
   } lane_cfg_type;

   typedef struct packed {
      logic fired;
      logic beep;
      logic latched;
      logic hit;
   } lane_res_type;

   function automatic logic [CNT_W-1:0] ones_count(input logic [HISTORY_BITS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

@@ rtl/core/bdwa_channels.sv @@
// Valid/ready channel interfaces for the request and response items of the
// button debounce core. Depends on bdwa_pkg.
interface bdwa_req_if import bdwa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [BUTTONS-1:0]  pressed_mask;
   logic [BUTTONS-1:0]  handler_accept;
   logic                deep_sleep;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, action, pressed_mask, handler_accept, deep_sleep, now_ms,
                   input ready);
   modport sink (input valid, action, pressed_mask, handler_accept, deep_sleep, now_ms,
                 output ready);
endinterface

interface bdwa_rsp_if import bdwa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BUTTONS-1:0] fired_mask;
   logic [BUTTONS-1:0] beep_mask;
   logic [BUTTONS-1:0] latched_mask;
   logic               active;

   modport source (output valid, fired_mask, beep_mask, latched_mask, active, input ready);
   modport sink (input valid, fired_mask, beep_mask, latched_mask, active, output ready);
endinterface

@@ rtl/core/bdwa_lane.sv @@
// One debounce lane: history, latch, done flag and press time of one button.
// Depends on bdwa_pkg.
module bdwa_lane import bdwa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  lane_in_type        cmd,
   input  logic [TIME_W-1:0]  now_ms,
   input  lane_cfg_type       cfg,
   output lane_res_type       res
);

   logic [HISTORY_BITS-1:0] history_ff, history_in;
   logic                    latched_ff, latched_in;
   logic                    done_ff, done_in;
   logic [TIME_W-1:0]       time_ff, time_in;

   logic [HISTORY_BITS-1:0] hist_shift;
   logic [CNT_W-1:0]        cnt;
   logic                    press_hit;
   logic                    release_hit;
   logic                    fired;
   logic [TIME_W-1:0]       elapsed;

   assign hist_shift  = {history_ff[HISTORY_BITS-2:0], cmd.pressed};
   assign cnt         = ones_count(hist_shift);
   assign press_hit   = CMP_W'(cnt) >= CMP_W'(cfg.press_thr);
   assign release_hit = CMP_W'(cnt) <= CMP_W'(cfg.release_thr);

   always_comb begin
      history_in = history_ff;
      latched_in = latched_ff;
      done_in    = done_ff;
      time_in    = time_ff;
      fired      = 1'b0;
      if (cmd.action) begin
         history_in = WAKE_HISTORY;
         latched_in = 1'b1;
         done_in    = 1'b1;
         time_in    = now_ms;
      end else begin
         history_in = hist_shift;
         if (cmd.pressed) begin
            if (press_hit) begin
               // The press time is stamped only on the sample that latches.
               if (!latched_ff) begin
                  time_in = now_ms;
               end
               latched_in = 1'b1;
               if (!done_ff && cmd.enable && cmd.accept) begin
                  done_in = 1'b1;
                  fired   = 1'b1;
               end
            end
         end else if (release_hit) begin
            latched_in = 1'b0;
            done_in    = 1'b0;
         end
      end
   end

   // Activity is judged against the press time as it stands after this item.
   assign elapsed     = now_ms - time_in;
   assign res.fired   = fired;
   assign res.beep    = fired && !cmd.sleeping;
   assign res.latched = latched_in;
   assign res.hit     = elapsed < TIME_W'(cfg.limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         latched_ff <= 1'b0;
         done_ff    <= 1'b0;
         time_ff    <= '0;
      end else if (step) begin
         history_ff <= history_in;
         latched_ff <= latched_in;
         done_ff    <= done_in;
         time_ff    <= time_in;
      end
   end

endmodule

@@ rtl/core/bdwa_merge.sv @@
// Merge stage: gathers the lane results into one response item and holds it
// in the output register until taken. Depends on bdwa_pkg and bdwa_rsp_if.
module bdwa_merge import bdwa_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic                             always_active,
   input  lane_res_type [BUTTONS-1:0]       lane_res,
   output logic                             free,
   bdwa_rsp_if.source                       rsp_chan
);

   logic               valid_ff;
   logic [BUTTONS-1:0] fired_ff, fired_in;
   logic [BUTTONS-1:0] beep_ff, beep_in;
   logic [BUTTONS-1:0] latched_ff, latched_in;
   logic               active_ff, active_in;
   logic [BUTTONS-1:0] hit;

   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         fired_in[i]   = lane_res[i].fired;
         beep_in[i]    = lane_res[i].beep;
         latched_in[i] = lane_res[i].latched;
         hit[i]        = lane_res[i].hit;
      end
   end

   assign active_in = always_active || (|hit);
   assign free      = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fired_ff   <= fired_in;
         beep_ff    <= beep_in;
         latched_ff <= latched_in;
         active_ff  <= active_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.fired_mask   = fired_ff;
   assign rsp_chan.beep_mask    = beep_ff;
   assign rsp_chan.latched_mask = latched_ff;
   assign rsp_chan.active       = active_ff;

endmodule

@@ rtl/core/button_debounce_with_activity_core.sv @@
// Button debounce core with activity detection, one lane per button.
// A response item is registered and valid in the cycle after its request item is accepted.
// Throughput: one item per cycle while responses are taken; the single output register
// sets it, and a new item is taken in the cycle that the held response is taken.
// Reset clears histories, latches, done flags, press times, the control registers and the
// response valid flag; both thresholds come out of reset at four.
module button_debounce_with_activity_core import bdwa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bdwa_req_if.sink               req_chan,
   bdwa_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [LIMIT_W-1:0]          limit_ff;
   logic [BUTTONS-1:0]          enable_ff;
   logic [THR_W-1:0]            press_thr_ff;
   logic [THR_W-1:0]            release_thr_ff;

   logic                        step;
   logic                        free;
   lane_cfg_type                lane_cfg;
   lane_in_type  [BUTTONS-1:0]  lane_cmd;
   lane_res_type [BUTTONS-1:0]  lane_res;

   // The timeout is kept as its limit in milliseconds; zero means always active.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= '0;
         enable_ff      <= '0;
         press_thr_ff   <= THRESHOLD_RESET;
         release_thr_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SLEEP_TIMEOUT: begin
               limit_ff <= LIMIT_W'(csr_wdata[TIMEOUT_W-1:0]) * TIMEOUT_UNIT_MS;
            end
            REG_HANDLER_ENABLE: begin
               enable_ff <= csr_wdata[BUTTONS-1:0];
            end
            REG_PRESS_THRESHOLD: begin
               press_thr_ff <= csr_wdata[THR_W-1:0];
            end
            REG_RELEASE_THRESHOLD: begin
               release_thr_ff <= csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = free;
   assign step           = req_chan.valid && free;

   assign lane_cfg.press_thr   = press_thr_ff;
   assign lane_cfg.release_thr = release_thr_ff;
   assign lane_cfg.limit       = limit_ff;

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      assign lane_cmd[g].action   = req_chan.action;
      assign lane_cmd[g].pressed  = req_chan.pressed_mask[g];
      assign lane_cmd[g].accept   = req_chan.handler_accept[g];
      assign lane_cmd[g].enable   = enable_ff[g];
      assign lane_cmd[g].sleeping = req_chan.deep_sleep;

      bdwa_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .cmd    (lane_cmd[g]),
         .now_ms (req_chan.now_ms),
         .cfg    (lane_cfg),
         .res    (lane_res[g])
      );
   end

   bdwa_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (step),
      .always_active (limit_ff == '0),
      .lane_res      (lane_res),
      .free          (free),
      .rsp_chan      (rsp_chan)
   );

endmodule

@@ rtl/core/bdwa_checker.sv @@
// Port-level checker for the button debounce core, bound to the top level.
// Depends on bdwa_pkg and the assertion macros header.
`include "button_debounce_with_activity_core_defines.svh"

module bdwa_checker import bdwa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BUTTONS-1:0] fired_mask,
   input logic [BUTTONS-1:0] beep_mask,
   input logic [BUTTONS-1:0] latched_mask
);

   logic stray_fire;

   // A button only fires while latched, and only beeps when it fires.
   assign stray_fire = |((fired_mask & ~latched_mask) | (beep_mask & ~fired_mask));

   // An empty output register never holds off a request item.
   `BDWA_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "request stalled while empty")
   // Every accepted request item shows up as a response in the next cycle.
   `BDWA_ASSERT_NEXT(a_rsp_follows_req, req_valid && req_ready, rsp_valid, "no response")
   // A pending response stays until it is taken.
   `BDWA_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `BDWA_ASSERT_NOW(a_fire_latched, rsp_valid, !stray_fire, "fire or beep without latch")

endmodule

bind button_debounce_with_activity_core bdwa_checker u_bdwa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .fired_mask   (rsp_chan.fired_mask),
   .beep_mask    (rsp_chan.beep_mask),
   .latched_mask (rsp_chan.latched_mask)
);
